// File: rtl/core/bucketed_hash_set_top_macros.svh
// ----------------------------------------------------------------------------
// Bucketed hash set assertion macros
// Implication and next-cycle checks shared by the core modules.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_SET_TOP_MACROS_SVH
`define BUCKETED_HASH_SET_TOP_MACROS_SVH

`ifndef SYNTH
`define BHS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BHS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BHS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BHS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/bhs_pkg.sv
// ----------------------------------------------------------------------------
// Bucketed hash set package
// Sizes, item types, operation codes and sequencer states of the core.
// ----------------------------------------------------------------------------
package bhs_pkg;

  localparam int NUM_BUCKETS  = 8;
  localparam int BUCKET_DEPTH = 8;
  localparam int KEY_WIDTH    = 31;

  localparam int SLOT_TOTAL = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int BUCKET_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int DEPTH_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int PTR_W      = $clog2(BUCKET_DEPTH + 1);
  localparam int SLOT_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int CNT_W      = $clog2(KEY_WIDTH + 1);

  localparam int CFG_W = 4;
  localparam int FUNC_W = 2;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 4'd8;

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [KEY_WIDTH-1:0] key;
  } req_t;

  typedef struct packed {
    logic found;
    logic full_res;
  } resp_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_FIN
  } state_t;

endpackage

// File: rtl/core/bhs_divider.sv
// ----------------------------------------------------------------------------
// Bucketed hash set modulo unit
// Restoring remainder of the key by the saturated bucket count, one bit a cycle.
// ----------------------------------------------------------------------------
`include "bucketed_hash_set_top_macros.svh"

module bhs_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bhs_pkg::KEY_WIDTH-1:0]  dividend,
  input  logic [bhs_pkg::CFG_W-1:0]      count,
  output bhs_pkg::div_stat_t             stat
);
  import bhs_pkg::*;

  logic [KEY_WIDTH-1:0] shreg;
  logic [CFG_W-1:0]     rem;
  logic [CFG_W-1:0]     rem_next;
  logic [CFG_W-1:0]     divisor;
  logic [CFG_W-1:0]     divisor_next;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [CFG_W:0]       partial;

  always_comb begin
    if (count == '0) begin
      divisor_next = CFG_W'(1);
    end else if (int'(count) > NUM_BUCKETS) begin
      divisor_next = CFG_W'(NUM_BUCKETS);
    end else begin
      divisor_next = count;
    end
  end

  always_comb begin
    partial = {rem, shreg[KEY_WIDTH-1]};
    if (partial >= {1'b0, divisor}) begin
      rem_next = CFG_W'(partial - {1'b0, divisor});
    end else begin
      rem_next = partial[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(KEY_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg   <= dividend;
      rem     <= '0;
      divisor <= divisor_next;
    end else if (busy) begin
      shreg <= {shreg[KEY_WIDTH-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign stat.done = done;
  assign stat.rem  = rem;

  `BHS_ASSERT_IMP(a_rem_below_divisor, clk, rst, done, rem < divisor)
  `BHS_ASSERT_NXT(a_start_sets_busy, clk, rst, start, busy)
  `BHS_ASSERT_IMP(a_busy_count_live, clk, rst, busy, cnt != '0)

endmodule

// File: rtl/core/bucketed_hash_set_top.sv
// ----------------------------------------------------------------------------
// Bucketed hash set
// Insert, search and remove of keys in fixed-depth buckets chosen by modulo.
// ----------------------------------------------------------------------------
// The key is reduced in the shared modulo unit, then the bucket is walked
// through the key memory read port, then the result register is loaded.
// One item is worked on at a time and the next is taken the cycle after the
// result is loaded.
// Reset is synchronous; it clears all valid bits at once and sets the bucket
// count to eight, with no clearing pass over the key memory.
`include "bucketed_hash_set_top_macros.svh"

module bucketed_hash_set_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  bhs_pkg::req_t                  req,
  output logic                           resp_valid,
  input  logic                           resp_stall,
  output bhs_pkg::resp_t                 resp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bhs_pkg::CFG_W-1:0]      cfg_data
);
  import bhs_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [CFG_W-1:0]      bucket_count;
  logic [FUNC_W-1:0]     op;
  logic [KEY_WIDTH-1:0]  key;
  logic [BUCKET_W-1:0]   bucket;
  logic [PTR_W-1:0]      ptr;
  logic                  pend;
  logic [DEPTH_W-1:0]    pend_idx;
  logic [KEY_WIDTH-1:0]  rd_key;
  logic [SLOT_TOTAL-1:0] slot_valid;
  logic [KEY_WIDTH-1:0]  slot_key [SLOT_TOTAL];
  logic                  res_found;
  logic                  res_full;
  div_stat_t             div_stat;

  logic                  accept;
  logic                  issue;
  logic [SLOT_W-1:0]     issue_addr;
  logic [SLOT_W-1:0]     pend_addr;
  logic                  is_hit;
  logic                  is_last;
  logic                  walk_end;
  logic                  load_resp;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  bhs_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (req.key),
    .count    (bucket_count),
    .stat     (div_stat)
  );

  assign issue_addr = SLOT_W'(int'(bucket) * BUCKET_DEPTH)
                    + SLOT_W'(ptr[DEPTH_W-1:0]);
  assign pend_addr  = SLOT_W'(int'(bucket) * BUCKET_DEPTH) + SLOT_W'(pend_idx);
  assign issue      = (state == ST_WALK) && (int'(ptr) < BUCKET_DEPTH);

  always_comb begin
    if (op == OP_INSERT) begin
      is_hit = pend && !slot_valid[pend_addr];
    end else if ((op == OP_SEARCH) || (op == OP_REMOVE)) begin
      is_hit = pend && slot_valid[pend_addr] && (rd_key == key);
    end else begin
      is_hit = 1'b0;
    end
  end

  assign is_last  = pend && (pend_idx == DEPTH_W'(BUCKET_DEPTH - 1));
  assign walk_end = (state == ST_WALK) && (is_hit || is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_resp  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!resp_valid || !resp_stall) begin
          load_resp  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
      slot_valid   <= '0;
      resp_valid   <= 1'b0;
      pend         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bucket_count <= cfg_data;
      end
      if (walk_end && is_hit) begin
        if (op == OP_INSERT) begin
          slot_valid[pend_addr] <= 1'b1;
        end else if (op == OP_REMOVE) begin
          slot_valid[pend_addr] <= 1'b0;
        end
      end
      if (load_resp) begin
        resp_valid <= 1'b1;
      end else if (!resp_stall) begin
        resp_valid <= 1'b0;
      end
      pend <= issue && !walk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.func;
      key <= req.key;
    end
    if (state == ST_DIV) begin
      bucket <= BUCKET_W'(div_stat.rem);
      ptr    <= '0;
    end else if (issue) begin
      ptr <= ptr + PTR_W'(1);
    end
    if (issue) begin
      pend_idx <= ptr[DEPTH_W-1:0];
    end
    if (walk_end) begin
      res_found <= is_hit && (op != OP_INSERT);
      res_full  <= !is_hit && (op == OP_INSERT);
    end
    if (load_resp) begin
      resp.found    <= res_found;
      resp.full_res <= res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_end && is_hit && (op == OP_INSERT)) begin
      slot_key[pend_addr] <= key;
    end
    if (issue) begin
      rd_key <= slot_key[issue_addr];
    end
  end

  `BHS_ASSERT_IMP(a_busy_stalls, clk, rst, state != ST_IDLE, req_stall)
  `BHS_ASSERT_IMP(a_div_done_in_div, clk, rst, div_stat.done, state == ST_DIV)
  `BHS_ASSERT_IMP(a_flags_exclusive, clk, rst, resp_valid && resp.full_res, !resp.found)

endmodule

// File: sim/bucketed_hash_set_top_tb.sv
// ----------------------------------------------------------------------------
// Bucketed hash set regression bench
// A directed table and randomised phases of insert, search and remove requests
// are driven under bursty requests and response stall, with the bucket count
// changed between phases while the core is idle. Each response is checked
// against its typed table value or an independent model of the bucket store.
// ----------------------------------------------------------------------------
module bucketed_hash_set_top_tb;
  import bhs_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_SHOWN    = 10;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 120;
  localparam int POOL_SIZE    = 12;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [FUNC_W-1:0]    OP_UNUSED = 2'd3;
  localparam logic [KEY_WIDTH-1:0] KEY_MAX   = {KEY_WIDTH{1'b1}};

  localparam resp_t RESP_NONE = '{found: 1'b0, full_res: 1'b0};
  localparam resp_t RESP_HIT  = '{found: 1'b1, full_res: 1'b0};
  localparam resp_t RESP_FULL = '{found: 1'b0, full_res: 1'b1};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_W-1:0] cfg_val;
    req_t             rq;
    logic             typed;
    resp_t            exp;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  localparam int NUM_DIRECTED = 25;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_REQ, 4'd0,  '{OP_SEARCH, 31'd0},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd0},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_SEARCH, 31'd0},         1'b1, RESP_HIT},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, KEY_MAX},       1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_SEARCH, KEY_MAX},       1'b1, RESP_HIT},
    '{ROW_REQ, 4'd0,  '{OP_REMOVE, KEY_MAX},       1'b1, RESP_HIT},
    '{ROW_REQ, 4'd0,  '{OP_REMOVE, KEY_MAX},       1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_UNUSED, KEY_MAX},       1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'd1},         1'b1, RESP_FULL},
    '{ROW_REQ, 4'd0,  '{OP_REMOVE, 31'd1},         1'b1, RESP_HIT},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'h5555_5555}, 1'b0, RESP_NONE},
    '{ROW_CFG, 4'd0,  '{OP_INSERT, 31'd0},         1'b0, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_SEARCH, 31'd1},         1'b0, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_INSERT, 31'h2AAA_AAAA}, 1'b0, RESP_NONE},
    '{ROW_CFG, 4'd15, '{OP_INSERT, 31'd0},         1'b0, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_SEARCH, 31'h2AAA_AAAA}, 1'b0, RESP_NONE},
    '{ROW_REQ, 4'd0,  '{OP_REMOVE, 31'h5555_5555}, 1'b0, RESP_NONE}
  };

  localparam logic [CFG_W-1:0] COUNT_PLAN [PHASES] = '{
    4'd1, 4'd8, 4'd3, 4'd0, 4'd5, 4'd12, 4'd2, 4'd7, 4'd9, 4'd4, 4'd15, 4'd6
  };

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             req_valid  = 1'b0;
  logic             req_stall;
  req_t             req        = '0;
  logic             resp_valid;
  logic             resp_stall = 1'b0;
  resp_t            resp;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data   = '0;

  logic [KEY_WIDTH-1:0] stored_key  [SLOT_TOTAL];
  logic                 stored_used [SLOT_TOTAL];
  logic [CFG_W-1:0]     active_buckets = BUCKET_COUNT_RESET;
  resp_t                pending_resp [$];

  int errors          = 0;
  int cycle_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int hits_seen       = 0;
  int drops_seen      = 0;
  int count_writes    = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  bucketed_hash_set_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    for (int s = 0; s < SLOT_TOTAL; s++) begin
      stored_used[s] = 1'b0;
      stored_key[s]  = '0;
    end
  end

  function automatic resp_t apply_request(input req_t r);
    resp_t res;
    int    bucket_div;
    int    slot_base;
    bit    done;
    res        = RESP_NONE;
    done       = 1'b0;
    bucket_div = int'(active_buckets);
    if (bucket_div == 0) bucket_div = 1;
    if (bucket_div > NUM_BUCKETS) bucket_div = NUM_BUCKETS;
    slot_base = int'(r.key % bucket_div) * BUCKET_DEPTH;
    case (r.func)
      OP_INSERT: begin
        res.full_res = 1'b1;
        for (int i = 0; i < BUCKET_DEPTH; i++) begin
          if (!done && !stored_used[slot_base + i]) begin
            stored_used[slot_base + i] = 1'b1;
            stored_key[slot_base + i]  = r.key;
            res.full_res = 1'b0;
            done = 1'b1;
          end
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        for (int i = 0; i < BUCKET_DEPTH; i++) begin
          if (!done && stored_used[slot_base + i] && stored_key[slot_base + i] == r.key) begin
            res.found = 1'b1;
            if (r.func == OP_REMOVE) stored_used[slot_base + i] = 1'b0;
            done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("%s", msg);
  endtask

  task automatic send_req(input req_t r, input logic typed, input resp_t typed_val);
    resp_t predicted;
    req_valid = 1'b1;
    req       = r;
    do @(posedge clk); while (req_stall);
    predicted = apply_request(r);
    pending_resp.insert(pending_resp.size(), typed ? typed_val : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_resp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] value);
    req_valid = 1'b0;
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    active_buckets = value;
    count_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  resp_stall <= 1'b0;
      STALL_LIGHT: resp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: resp_stall <= ($urandom_range(0, 3) != 0);
      default:     resp_stall <= ((stall_left % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    resp_t want;
    if (!rst && resp_valid && !resp_stall) begin
      if (pending_resp.size() == 0) begin
        report($sformatf("unexpected response found=%0b full_res=%0b", resp.found,
                         resp.full_res));
      end else begin
        want = pending_resp.pop_front();
        if (resp.found !== want.found)
          report($sformatf("response %0d found: expected %0b, got %0b", results_checked,
                           want.found, resp.found));
        if (resp.full_res !== want.full_res)
          report($sformatf("response %0d full_res: expected %0b, got %0b", results_checked,
                           want.full_res, resp.full_res));
        if (want.found) hits_seen++;
        if (want.full_res) drops_seen++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d responses outstanding", cycle_count,
               pending_resp.size());
      $display("bucketed_hash_set_top regression: fail");
      $finish;
    end
  end

  initial begin
    logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
    req_t                 r;
    int                   pick;
    int                   insert_pct;
    int                   burst_left;
    bit                   quiet;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_bucket_count(DIRECTED[i].cfg_val);
      end else begin
        send_req(DIRECTED[i].rq, DIRECTED[i].typed, DIRECTED[i].exp);
      end
    end

    // Half the key pool is carried into each phase, so keys stored under one
    // bucket count are looked up again under the next.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_bucket_count(COUNT_PLAN[phase]);
      for (int k = 0; k < POOL_SIZE; k++) begin
        if (phase == 0 || k % 2 == 0) begin
          if ($urandom_range(0, 3) == 0) key_pool[k] = KEY_WIDTH'($urandom_range(0, 63));
          else key_pool[k] = KEY_WIDTH'($urandom);
        end
      end
      quiet      = (phase % 4 == 1);
      insert_pct = (phase % 2 == 0) ? 45 : 25;
      burst_left = $urandom_range(1, 16);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) r.func = OP_INSERT;
        else if (pick < insert_pct + 30) r.func = OP_SEARCH;
        else if (pick < 95) r.func = OP_REMOVE;
        else r.func = OP_UNUSED;
        if ($urandom_range(0, 9) == 0) r.key = KEY_WIDTH'($urandom);
        else r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_req(r, 1'b0, RESP_NONE);
        if (!quiet) begin
          if (burst_left == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
          end else begin
            burst_left--;
          end
        end
      end
    end

    req_valid = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_resp.size() != 0)
      report($sformatf("%0d responses never arrived", pending_resp.size()));

    $display("Sent %0d requests across %0d bucket-count writes, zero and over-range included.",
             items_sent, count_writes);
    $display("Checked %0d responses: %0d hits, %0d inserts dropped on a full bucket.",
             results_checked, hits_seen, drops_seen);
    if (errors == 0) begin
      $display("bucketed_hash_set_top regression: pass");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("bucketed_hash_set_top regression: fail");
    end
    $finish;
  end

endmodule
